/* src/ppdu_pkg.sv */
// Shared types and register indexes for the pinhole projection unit.
package ppdu_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRINC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_K3      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P1      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_P2      = 3'd7;

    localparam int unsigned FRAC_BITS = 28;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               behind_camera;
        logic               saturated;
    } t_pixel;

endpackage

/* src/pinhole_projection_with_distortion_unit.sv */
// Top level of the pinhole projection unit with radial and tangential distortion.
//
// A camera-frame point word enters on i_point when i_valid and o_ready are both
// high; a pixel word leaves on o_pixel when o_valid and i_ready are both high.
// The datapath is a 23-stage pipeline; one point can be accepted every cycle
// unless a stalled receiver has filled the pipeline. The depth is set by
// two 32-step restoring dividers, four quotient bits per stage, followed by the
// chain of registered multiplies of the distortion and scaling terms.
// Each stage holds its word until the next stage is free, so a stalled receiver
// only fills the pipeline; nothing is dropped or repeated. When the output stage
// is empty the input side is always ready.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must do so only while no point is in flight (not enforced by the block).
// Reset empties the pipeline and clears every configuration register.
module pinhole_projection_with_distortion_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  ppdu_pkg::t_point                 i_point,
    output logic                             o_valid,
    input  logic                             i_ready,
    output ppdu_pkg::t_pixel                 o_pixel,
    input  logic                             i_cfg_we,
    input  logic [ppdu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]                      i_cfg_data
);

    localparam int NST = 23;
    localparam int DIV_FIRST = 1;
    localparam int DIV_LAST = 8;
    localparam int STEPS = 4;

    typedef struct packed {
        logic               behind;
        logic               sat;
        logic               dsat;
        logic               negx;
        logic               negy;
        logic               ovfx;
        logic               ovfy;
        logic [31:0]        dvs;
        logic [32:0]        rx;
        logic [32:0]        ry;
        logic [31:0]        qx;
        logic [31:0]        qy;
        logic [31:0]        nx;
        logic [31:0]        ny;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] xy;
        logic signed [31:0] r2;
        logic signed [31:0] r4;
        logic signed [31:0] r6;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] a3;
        logic signed [31:0] cd;
        logic signed [64:0] m0;
        logic signed [64:0] m1;
        logic signed [64:0] m2;
        logic signed [64:0] m3;
        logic signed [64:0] m4;
        logic signed [64:0] m5;
    } t_stage;

    logic               r_dist_en;
    logic [63:0]        r_focal;
    logic [63:0]        r_princ;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_k2;
    logic signed [31:0] r_k3;
    logic signed [31:0] r_p1;
    logic signed [31:0] r_p2;

    t_stage             r_st [NST];
    t_stage             n_st [NST];
    logic [NST-1:0]     r_vld;
    logic [NST:0]       w_en;

    function automatic logic [32:0] clamp32(input logic signed [39:0] v);
        logic [32:0] res;
        if (v > 40'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -40'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    function automatic logic signed [39:0] qsh(input logic signed [64:0] m);
        logic signed [36:0] s;
        s = m[64:ppdu_pkg::FRAC_BITS];
        return 40'(s);
    endfunction

    function automatic logic [64:0] div_steps(input logic [32:0] rem, input logic [31:0] q,
                                               input logic [31:0] bits,
                                               input logic [31:0] dvs);
        logic [32:0] r;
        logic [31:0] qq;
        r = rem;
        qq = q;
        for (int s = 0; s < STEPS; s++) begin
            r = {r[31:0], bits[31-s]};
            qq = {qq[30:0], 1'b0};
            if (r >= {1'b0, dvs}) begin
                r = r - {1'b0, dvs};
                qq[0] = 1'b1;
            end
        end
        return {r[32:1] == 32'd0 ? 1'b0 : 1'b0, r[31:0], qq};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_en <= 1'b0;
            r_focal   <= '0;
            r_princ   <= '0;
            r_k1      <= '0;
            r_k2      <= '0;
            r_k3      <= '0;
            r_p1      <= '0;
            r_p2      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppdu_pkg::REG_DIST_EN: r_dist_en <= i_cfg_data[0];
                ppdu_pkg::REG_FOCAL:   r_focal   <= i_cfg_data;
                ppdu_pkg::REG_PRINC:   r_princ   <= i_cfg_data;
                ppdu_pkg::REG_K1:      r_k1      <= i_cfg_data[31:0];
                ppdu_pkg::REG_K2:      r_k2      <= i_cfg_data[31:0];
                ppdu_pkg::REG_K3:      r_k3      <= i_cfg_data[31:0];
                ppdu_pkg::REG_P1:      r_p1      <= i_cfg_data[31:0];
                ppdu_pkg::REG_P2:      r_p2      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_en[NST] = i_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign o_ready = w_en[0];

    always_comb begin
        logic [31:0]        magx;
        logic [31:0]        magy;
        logic [64:0]        dres;
        logic [32:0]        c0;
        logic [32:0]        c1;
        logic [32:0]        c2;
        logic [32:0]        c3;
        logic signed [39:0] sx;
        logic signed [39:0] sy;

        magx = '0;
        magy = '0;
        dres = '0;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        sx = '0;
        sy = '0;

        n_st[0] = r_st[0];
        n_st[0].behind = (i_point.point_z <= 32'sd0);
        n_st[0].sat    = 1'b0;
        n_st[0].dsat   = 1'b0;
        n_st[0].negx   = i_point.point_x[31];
        n_st[0].negy   = i_point.point_y[31];
        magx = i_point.point_x[31] ? 32'(-i_point.point_x) : i_point.point_x;
        magy = i_point.point_y[31] ? 32'(-i_point.point_y) : i_point.point_y;
        n_st[0].dvs = n_st[0].behind ? 32'd1 : i_point.point_z;
        n_st[0].ovfx = ({4'd0, magx[31:4]} >= n_st[0].dvs);
        n_st[0].ovfy = ({4'd0, magy[31:4]} >= n_st[0].dvs);
        n_st[0].rx = {5'd0, magx[31:4]};
        n_st[0].ry = {5'd0, magy[31:4]};
        n_st[0].qx = '0;
        n_st[0].qy = '0;
        n_st[0].nx = {magx[3:0], 28'd0};
        n_st[0].ny = {magy[3:0], 28'd0};

        for (int i = 1; i < NST; i++) begin
            n_st[i] = r_st[i-1];
            if (i >= DIV_FIRST && i <= DIV_LAST) begin
                dres = div_steps(r_st[i-1].rx, r_st[i-1].qx, r_st[i-1].nx, r_st[i-1].dvs);
                n_st[i].rx = {1'b0, dres[63:32]};
                n_st[i].qx = dres[31:0];
                dres = div_steps(r_st[i-1].ry, r_st[i-1].qy, r_st[i-1].ny, r_st[i-1].dvs);
                n_st[i].ry = {1'b0, dres[63:32]};
                n_st[i].qy = dres[31:0];
                n_st[i].nx = {r_st[i-1].nx[31-STEPS:0], {STEPS{1'b0}}};
                n_st[i].ny = {r_st[i-1].ny[31-STEPS:0], {STEPS{1'b0}}};
            end
            case (i)
                9: begin
                    sx = 40'(signed'({8'd0, r_st[i-1].qx}));
                    sy = 40'(signed'({8'd0, r_st[i-1].qy}));
                    c0 = clamp32(r_st[i-1].negx ? -sx : sx);
                    c1 = clamp32(r_st[i-1].negy ? -sy : sy);
                    if (r_st[i-1].ovfx) begin
                        c0 = {1'b1, r_st[i-1].negx ? 32'h8000_0000 : 32'h7FFF_FFFF};
                    end
                    if (r_st[i-1].ovfy) begin
                        c1 = {1'b1, r_st[i-1].negy ? 32'h8000_0000 : 32'h7FFF_FFFF};
                    end
                    n_st[i].x = c0[31:0];
                    n_st[i].y = c1[31:0];
                    n_st[i].sat = c0[32] | c1[32];
                end
                10: begin
                    n_st[i].m0 = 65'(r_st[i-1].x * r_st[i-1].x);
                    n_st[i].m1 = 65'(r_st[i-1].y * r_st[i-1].y);
                    n_st[i].m2 = 65'(r_st[i-1].x * r_st[i-1].y);
                end
                11: begin
                    c0 = clamp32(qsh(r_st[i-1].m0));
                    c1 = clamp32(qsh(r_st[i-1].m1));
                    c2 = clamp32(qsh(r_st[i-1].m2));
                    c3 = clamp32(40'(signed'(c0[31:0])) + 40'(signed'(c1[31:0])));
                    n_st[i].xx = c0[31:0];
                    n_st[i].yy = c1[31:0];
                    n_st[i].xy = c2[31:0];
                    n_st[i].r2 = c3[31:0];
                    n_st[i].dsat = c0[32] | c1[32] | c2[32] | c3[32];
                end
                12: begin
                    n_st[i].m0 = 65'(r_st[i-1].r2 * r_st[i-1].r2);
                    n_st[i].m1 = 65'(r_k1 * r_st[i-1].r2);
                    c0 = clamp32(40'(r_st[i-1].xy) + 40'(r_st[i-1].xy));
                    c1 = clamp32(40'(r_st[i-1].r2) + 40'(r_st[i-1].xx) + 40'(r_st[i-1].xx));
                    c2 = clamp32(40'(r_st[i-1].r2) + 40'(r_st[i-1].yy) + 40'(r_st[i-1].yy));
                    n_st[i].a1 = c0[31:0];
                    n_st[i].a2 = c1[31:0];
                    n_st[i].a3 = c2[31:0];
                    n_st[i].dsat = r_st[i-1].dsat | c0[32] | c1[32] | c2[32];
                end
                13: begin
                    c0 = clamp32(qsh(r_st[i-1].m0));
                    n_st[i].r4 = c0[31:0];
                    n_st[i].dsat = r_st[i-1].dsat | c0[32];
                end
                14: begin
                    n_st[i].m0 = 65'(r_st[i-1].r4 * r_st[i-1].r2);
                    n_st[i].m2 = 65'(r_k2 * r_st[i-1].r4);
                end
                15: begin
                    c0 = clamp32(qsh(r_st[i-1].m0));
                    n_st[i].r6 = c0[31:0];
                    n_st[i].dsat = r_st[i-1].dsat | c0[32];
                end
                16: begin
                    n_st[i].m0 = 65'(r_k3 * r_st[i-1].r6);
                end
                17: begin
                    c0 = clamp32((40'sd1 <<< ppdu_pkg::FRAC_BITS) + qsh(r_st[i-1].m1)
                                 + qsh(r_st[i-1].m2) + qsh(r_st[i-1].m0));
                    n_st[i].cd = c0[31:0];
                    n_st[i].dsat = r_st[i-1].dsat | c0[32];
                end
                18: begin
                    n_st[i].m0 = 65'(r_st[i-1].x * r_st[i-1].cd);
                    n_st[i].m1 = 65'(r_p1 * r_st[i-1].a1);
                    n_st[i].m2 = 65'(r_p2 * r_st[i-1].a2);
                    n_st[i].m3 = 65'(r_st[i-1].y * r_st[i-1].cd);
                    n_st[i].m4 = 65'(r_p1 * r_st[i-1].a3);
                    n_st[i].m5 = 65'(r_p2 * r_st[i-1].a1);
                end
                19: begin
                    c0 = clamp32(qsh(r_st[i-1].m0) + qsh(r_st[i-1].m1) + qsh(r_st[i-1].m2));
                    c1 = clamp32(qsh(r_st[i-1].m3) + qsh(r_st[i-1].m4) + qsh(r_st[i-1].m5));
                    if (r_dist_en) begin
                        n_st[i].x = c0[31:0];
                        n_st[i].y = c1[31:0];
                        n_st[i].sat = r_st[i-1].sat | r_st[i-1].dsat | c0[32] | c1[32];
                    end
                end
                20: begin
                    n_st[i].m0 = 65'(r_st[i-1].x * $signed({1'b0, r_focal[63:32]}));
                    n_st[i].m1 = 65'(r_st[i-1].y * $signed({1'b0, r_focal[31:0]}));
                end
                21: begin
                    c0 = clamp32(qsh(r_st[i-1].m0) + 40'(signed'({1'b0, r_princ[63:32]})));
                    c1 = clamp32(qsh(r_st[i-1].m1) + 40'(signed'({1'b0, r_princ[31:0]})));
                    n_st[i].x = c0[31:0];
                    n_st[i].y = c1[31:0];
                    n_st[i].sat = r_st[i-1].sat | c0[32] | c1[32];
                end
                22: begin
                    if (r_st[i-1].behind) begin
                        n_st[i].x = '0;
                        n_st[i].y = '0;
                        n_st[i].sat = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NST; i++) begin
            if (w_en[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_valid               = r_vld[NST-1];
    assign o_pixel.pixel_u       = r_st[NST-1].x;
    assign o_pixel.pixel_v       = r_st[NST-1].y;
    assign o_pixel.behind_camera = r_st[NST-1].behind;
    assign o_pixel.saturated     = r_st[NST-1].sat;

endmodule

/* src/ppdu_checker.sv */
// Port-level checker for the pinhole projection unit and its bind statement.
module ppdu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input ppdu_pkg::t_pixel o_pixel
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel))
        else $error("Output word changed while stalled.");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel.behind_camera |->
            o_pixel.pixel_u == 32'sd0 && o_pixel.pixel_v == 32'sd0 && !o_pixel.saturated)
        else $error("A point behind the camera gave a non-zero pixel word.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input not ready while the output stage is empty.");

endmodule

bind pinhole_projection_with_distortion_unit ppdu_checker u_ppdu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_pixel (o_pixel)
);

/* test/pinhole_projection_with_distortion_unit_test.sv */
// Self-checking testbench for the pinhole projection unit with lens distortion.
module pinhole_projection_with_distortion_unit_test;

    localparam int LATENCY = 22;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_POINTS = 850;
    localparam longint Q_ONE = 64'sd1 << ppdu_pkg::FRAC_BITS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    ppdu_pkg::t_point i_point = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    ppdu_pkg::t_pixel o_pixel;
    logic i_cfg_we = 1'b0;
    logic [ppdu_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    pinhole_projection_with_distortion_unit uut (.*);

    always #1 i_clk = ~i_clk;

    logic dist_on;
    logic [63:0] focal, princ;
    longint k1, k2, k3, p1, p2;

    ppdu_pkg::t_pixel pending_pixels[$];
    int errors = 0;
    longint cycles = 0;
    logic feeding_done = 1'b0;
    logic out_taken = 1'b0;
    int ready_wait = 0;

    typedef struct {
        ppdu_pkg::t_point pt;
        logic known;
        ppdu_pkg::t_pixel px;
    } t_row;

    function automatic longint clamp32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fixmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> ppdu_pkg::FRAC_BITS;
    endfunction

    function automatic ppdu_pkg::t_pixel project(ppdu_pkg::t_point pt);
        ppdu_pkg::t_pixel r;
        logic sat;
        longint x, y, xx, yy, xy, r2, r4, r6, a1, a2, a3, cd, xd, yd;
        longint px, py, pz, fx, fy, cx, cy;
        r = '0;
        sat = 1'b0;
        px = longint'(pt.point_x);
        py = longint'(pt.point_y);
        pz = longint'(pt.point_z);
        fx = longint'({32'd0, focal[63:32]});
        fy = longint'({32'd0, focal[31:0]});
        cx = longint'({32'd0, princ[63:32]});
        cy = longint'({32'd0, princ[31:0]});
        if (pz <= 0) begin
            r.behind_camera = 1'b1;
            return r;
        end
        x = clamp32((px * Q_ONE) / pz, sat);
        y = clamp32((py * Q_ONE) / pz, sat);
        if (dist_on) begin
            xx = clamp32(fixmul(x, x), sat);
            yy = clamp32(fixmul(y, y), sat);
            xy = clamp32(fixmul(x, y), sat);
            r2 = clamp32(xx + yy, sat);
            r4 = clamp32(fixmul(r2, r2), sat);
            r6 = clamp32(fixmul(r4, r2), sat);
            a1 = clamp32(2 * xy, sat);
            a2 = clamp32(r2 + 2 * xx, sat);
            a3 = clamp32(r2 + 2 * yy, sat);
            cd = clamp32(Q_ONE + fixmul(k1, r2) + fixmul(k2, r4) + fixmul(k3, r6), sat);
            xd = clamp32(fixmul(x, cd) + fixmul(p1, a1) + fixmul(p2, a2), sat);
            yd = clamp32(fixmul(y, cd) + fixmul(p1, a3) + fixmul(p2, a1), sat);
            x = xd;
            y = yd;
        end
        r.pixel_u = 32'(clamp32(fixmul(x, fx) + cx, sat));
        r.pixel_v = 32'(clamp32(fixmul(y, fy) + cy, sat));
        r.saturated = sat;
        return r;
    endfunction

    task automatic write_reg(logic [ppdu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            ppdu_pkg::REG_DIST_EN: dist_on = value[0];
            ppdu_pkg::REG_FOCAL: focal = value;
            ppdu_pkg::REG_PRINC: princ = value;
            ppdu_pkg::REG_K1: k1 = longint'(signed'(value[31:0]));
            ppdu_pkg::REG_K2: k2 = longint'(signed'(value[31:0]));
            ppdu_pkg::REG_K3: k3 = longint'(signed'(value[31:0]));
            ppdu_pkg::REG_P1: p1 = longint'(signed'(value[31:0]));
            ppdu_pkg::REG_P2: p2 = longint'(signed'(value[31:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic send_point(ppdu_pkg::t_point pt, logic known, ppdu_pkg::t_pixel want);
        ppdu_pkg::t_pixel model;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        model = project(pt);
        if (known && model !== want) begin
            $display("%0t: table row mismatch expected %h actual %h", $time, want, model);
            errors++;
        end
        i_valid <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (!o_ready);
        pending_pixels.push_back(model);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 15);
            2: return 32'h7fff_fff0 | $urandom_range(0, 15);
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h0;
            2: return 32'h7fff_ffff;
            3: return 32'h1;
            default: return 32'($urandom_range(1 << 14, 1 << 22));
        endcase
    endfunction

    function automatic logic [63:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return {$urandom(), $urandom()};
            1: return 64'h0000_0000_8000_0000;
            2: return 64'h0000_0000_7fff_ffff;
            default: return {32'd0, 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25))};
        endcase
    endfunction

    t_row directed[] = '{
        '{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
        '{'{32'sh7fffffff, -32'sd1, -32'sd65536}, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
        '{'{32'sh7fffffff, 32'sh80000000, 32'sh80000000}, 1'b1,
          '{32'sd0, 32'sd0, 1'b1, 1'b0}},
        '{'{32'sd65536, 32'sd65536, 32'sd65536}, 1'b0, '0},
        '{'{32'sh7fffffff, 32'sh80000000, 32'sd1}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0},
        '{'{-32'sd32768, 32'sd98304, 32'sd131072}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 32'sd1}, 1'b0, '0}
    };

    always @(posedge i_clk) begin
        ppdu_pkg::t_pixel want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            out_taken = 1'b1;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel word %h", $time, o_pixel);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel.pixel_u !== want.pixel_u)
                    $display("%0t: pixel_u expected %h actual %h", $time,
                             want.pixel_u, o_pixel.pixel_u);
                if (o_pixel.pixel_v !== want.pixel_v)
                    $display("%0t: pixel_v expected %h actual %h", $time,
                             want.pixel_v, o_pixel.pixel_v);
                if (o_pixel.behind_camera !== want.behind_camera)
                    $display("%0t: behind_camera expected %b actual %b", $time,
                             want.behind_camera, o_pixel.behind_camera);
                if (o_pixel.saturated !== want.saturated)
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, o_pixel.saturated);
                if (o_pixel !== want) errors++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL pinhole_projection_with_distortion_unit");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
            if (out_taken) begin
                out_taken = 1'b0;
                ready_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
            if (ready_wait != 0) begin
                ready_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        dist_on = 1'b0;
        focal = '0;
        princ = '0;
        k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n])
            send_point(directed[n].pt, directed[n].known, directed[n].px);
        wait_drained();

        write_reg(ppdu_pkg::REG_FOCAL, {32'd500 << 16, 32'd480 << 16});
        write_reg(ppdu_pkg::REG_PRINC, {32'd320 << 16, 32'd240 << 16});
        write_reg(ppdu_pkg::REG_DIST_EN, 64'd1);
        write_reg(ppdu_pkg::REG_K1, 64'(32'hf800_0000));
        write_reg(ppdu_pkg::REG_K2, 64'(32'h0100_0000));
        write_reg(ppdu_pkg::REG_K3, 64'(32'h0010_0000));
        write_reg(ppdu_pkg::REG_P1, 64'(32'h0001_0000));
        write_reg(ppdu_pkg::REG_P2, 64'(32'hffff_0000));
        foreach (directed[n])
            send_point(directed[n].pt, 1'b0, '0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                write_reg(ppdu_pkg::REG_FOCAL, '1);
                write_reg(ppdu_pkg::REG_PRINC, '1);
                write_reg(ppdu_pkg::REG_K1, 64'h7fff_ffff);
                write_reg(ppdu_pkg::REG_K2, 64'h8000_0000);
                write_reg(ppdu_pkg::REG_K3, 64'h7fff_ffff);
                write_reg(ppdu_pkg::REG_P1, 64'h8000_0000);
                write_reg(ppdu_pkg::REG_P2, 64'h7fff_ffff);
            end else begin
                write_reg(ppdu_pkg::REG_FOCAL, {$urandom_range(0, 3) == 0 ? $urandom() :
                                      32'($urandom_range(1 << 16, 2000 << 16)),
                                      $urandom_range(0, 3) == 0 ? $urandom() :
                                      32'($urandom_range(1 << 16, 2000 << 16))});
                write_reg(ppdu_pkg::REG_PRINC, {$urandom_range(0, 3) == 0 ? $urandom() :
                                      32'($urandom_range(0, 1000 << 16)),
                                      $urandom_range(0, 3) == 0 ? $urandom() :
                                      32'($urandom_range(0, 1000 << 16))});
                write_reg(ppdu_pkg::REG_K1, rand_coef());
                write_reg(ppdu_pkg::REG_K2, rand_coef());
                write_reg(ppdu_pkg::REG_K3, rand_coef());
                write_reg(ppdu_pkg::REG_P1, rand_coef());
                write_reg(ppdu_pkg::REG_P2, rand_coef());
            end
            write_reg(ppdu_pkg::REG_DIST_EN, {$urandom(), $urandom()} | 64'(phase != 2));
            for (int n = 0; n < RANDOM_POINTS / 6; n++)
                send_point('{rand_coord(), rand_coord(), rand_depth()}, 1'b0, '0);
            wait_drained();
        end

        if (errors == 0)
            $display("PASS pinhole_projection_with_distortion_unit");
        else
            $display("FAIL pinhole_projection_with_distortion_unit");
        $finish;
    end
endmodule

/* filelist.f */
src/ppdu_pkg.sv
src/pinhole_projection_with_distortion_unit.sv
src/ppdu_checker.sv
test/pinhole_projection_with_distortion_unit_test.sv
